// ----- src/uvsph_pkg.sv -----
// ============================================================================
// UV sphere tessellator package
// Shared widths, constants, the cell and vertex types and the small tables.
// ============================================================================
package uvsph_pkg;

  localparam int MAX_DIVISIONS = 1024;
  localparam int CORDIC_STEPS  = 16;
  localparam int ATAN_LEN      = 24;
  localparam int ATAN_IW       = 5;
  localparam int CNT_W         = 11;
  localparam int IDX_W         = 10;
  localparam int ANG_W         = 37;
  localparam int XY_W          = 34;
  localparam int DIV_W         = 46;
  localparam int REM_W         = CNT_W + 1;
  localparam int TEX_W         = 17;
  localparam int POS_W         = 17;
  localparam int NRM_W         = 16;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_SLICES = 2'd1;
  localparam logic [1:0] REG_STACKS = 2'd2;

  localparam logic signed [ANG_W-1:0] PI_Q32      = 37'sd13493037704;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q32  = 37'sd26986075408;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q32 = 37'sd6746518852;
  localparam logic [DIV_W-1:0]        PI_U        = 46'd13493037704;
  localparam logic [DIV_W-1:0]        TWO_PI_U    = 46'd26986075408;
  localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic             err;
    logic [IDX_W-1:0] stack;
    logic [IDX_W-1:0] slice;
  } cell_t;

  typedef struct packed {
    logic signed [POS_W-1:0] vertex_x;
    logic signed [POS_W-1:0] vertex_y;
    logic signed [POS_W-1:0] vertex_z;
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic [TEX_W-1:0]        tex_u;
    logic [TEX_W-1:0]        tex_v;
    logic [2:0]              corner_number;
    logic                    last_of_cell;
    logic                    index_error;
  } vertex_t;

  function automatic logic signed [ANG_W-1:0] atan_q32(input logic [ATAN_IW-1:0] k);
    case (k)
      5'd0:    return 37'sd3373259426;
      5'd1:    return 37'sd1991351318;
      5'd2:    return 37'sd1052175346;
      5'd3:    return 37'sd534100635;
      5'd4:    return 37'sd268086748;
      5'd5:    return 37'sd134174062;
      5'd6:    return 37'sd67103403;
      5'd7:    return 37'sd33553749;
      5'd8:    return 37'sd16777131;
      5'd9:    return 37'sd8388597;
      5'd10:   return 37'sd4194303;
      5'd11:   return 37'sd2097152;
      5'd12:   return 37'sd1048576;
      5'd13:   return 37'sd524288;
      5'd14:   return 37'sd262144;
      5'd15:   return 37'sd131072;
      5'd16:   return 37'sd65536;
      5'd17:   return 37'sd32768;
      5'd18:   return 37'sd16384;
      5'd19:   return 37'sd8192;
      5'd20:   return 37'sd4096;
      5'd21:   return 37'sd2048;
      5'd22:   return 37'sd1024;
      5'd23:   return 37'sd512;
      default: return '0;
    endcase
  endfunction

  // Corner order p2,p4,p3,p3,p1,p2 as stack and slice offsets.
  function automatic logic corner_ds(input logic [2:0] c);
    case (c)
      3'd1, 3'd2, 3'd3: return 1'b1;
      default:          return 1'b0;
    endcase
  endfunction

  function automatic logic corner_dt(input logic [2:0] c);
    case (c)
      3'd0, 3'd1, 3'd5: return 1'b1;
      default:          return 1'b0;
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v);
    if (v == '0) begin
      return CNT_W'(1);
    end else if (32'(v) > MAX_DIVISIONS) begin
      return CNT_W'(MAX_DIVISIONS);
    end
    return v;
  endfunction

endpackage

// ----- src/uvsph_front.sv -----
// ============================================================================
// UV sphere tessellator front end
// Accepts cell transactions, flags cells outside the grid and queues them.
// ============================================================================
module uvsph_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [uvsph_pkg::IDX_W-1:0]   stack_index,
  input  logic [uvsph_pkg::IDX_W-1:0]   slice_index,
  input  logic [uvsph_pkg::CNT_W-1:0]   slices,
  input  logic [uvsph_pkg::CNT_W-1:0]   stacks,
  input  logic                          cell_pop,
  output logic                          cell_empty,
  output uvsph_pkg::cell_t              cell_head
);

  uvsph_pkg::cell_t queue [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       wr_en;
  logic       rd_en;
  uvsph_pkg::cell_t incoming;

  assign full       = (count == 3'd4);
  assign cell_empty = (count == 3'd0);
  assign wr_en      = push && !full;
  assign rd_en      = cell_pop && !cell_empty;
  assign cell_head  = queue[rd_ptr];

  always_comb begin
    incoming.stack = stack_index;
    incoming.slice = slice_index;
    incoming.err   = ({1'b0, stack_index} >= stacks) || ({1'b0, slice_index} >= slices);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        queue[wr_ptr] <= incoming;
        wr_ptr        <= wr_ptr + 2'd1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 3'd1;
        2'b01:   count <= count - 3'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- src/uvsph_divider.sv -----
// ============================================================================
// UV sphere tessellator divider
// Restoring divider that produces one quotient bit per cycle.
// ============================================================================
module uvsph_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [uvsph_pkg::DIV_W-1:0]   dividend,
  input  logic [uvsph_pkg::CNT_W-1:0]   divisor,
  output logic                          done,
  output logic [uvsph_pkg::DIV_W-1:0]   quotient
);

  localparam int CW = $clog2(uvsph_pkg::DIV_W);

  logic                          busy;
  logic [CW-1:0]                 cnt;
  logic [uvsph_pkg::REM_W-1:0]   rem;
  logic [uvsph_pkg::CNT_W-1:0]   dsr;
  logic [uvsph_pkg::REM_W-1:0]   trial;
  logic                          fits;

  assign trial = {rem[uvsph_pkg::REM_W-2:0], quotient[uvsph_pkg::DIV_W-1]};
  assign fits  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dsr      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= fits ? (trial - {1'b0, dsr}) : trial;
        quotient <= {quotient[uvsph_pkg::DIV_W-2:0], fits};
        cnt      <= cnt + CW'(1);
        if (cnt == CW'(uvsph_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/uvsph_cordic.sv -----
// ============================================================================
// UV sphere tessellator CORDIC
// Rotation-mode CORDIC, one iteration per cycle, giving sine and cosine.
// ============================================================================
module uvsph_cordic #(
  parameter int CORDIC_STEPS = uvsph_pkg::CORDIC_STEPS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [uvsph_pkg::ANG_W-1:0]  theta,
  output logic                                done,
  output logic signed [uvsph_pkg::XY_W-1:0]   sin_o,
  output logic signed [uvsph_pkg::XY_W-1:0]   cos_o
);

  localparam int NSTEP = (CORDIC_STEPS < uvsph_pkg::ATAN_LEN) ? CORDIC_STEPS :
                         uvsph_pkg::ATAN_LEN;

  logic                                busy;
  logic                                neg;
  logic [uvsph_pkg::ATAN_IW-1:0]       k;
  logic signed [uvsph_pkg::XY_W-1:0]   x;
  logic signed [uvsph_pkg::XY_W-1:0]   y;
  logic signed [uvsph_pkg::ANG_W-1:0]  z;
  logic signed [uvsph_pkg::ANG_W-1:0]  wrapped;
  logic signed [uvsph_pkg::ANG_W-1:0]  folded;
  logic                                fold_neg;
  logic signed [uvsph_pkg::XY_W-1:0]   x_n;
  logic signed [uvsph_pkg::XY_W-1:0]   y_n;
  logic signed [uvsph_pkg::ANG_W-1:0]  z_n;

  always_comb begin
    wrapped  = (theta > uvsph_pkg::PI_Q32) ? theta - uvsph_pkg::TWO_PI_Q32 : theta;
    fold_neg = 1'b0;
    folded   = wrapped;
    if (wrapped > uvsph_pkg::HALF_PI_Q32) begin
      folded   = wrapped - uvsph_pkg::PI_Q32;
      fold_neg = 1'b1;
    end else if (wrapped < -uvsph_pkg::HALF_PI_Q32) begin
      folded   = wrapped + uvsph_pkg::PI_Q32;
      fold_neg = 1'b1;
    end
  end

  always_comb begin
    if (!z[uvsph_pkg::ANG_W-1]) begin
      x_n = x - (y >>> k);
      y_n = y + (x >>> k);
      z_n = z - uvsph_pkg::atan_q32(k);
    end else begin
      x_n = x + (y >>> k);
      y_n = y - (x >>> k);
      z_n = z + uvsph_pkg::atan_q32(k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        k    <= '0;
        x    <= uvsph_pkg::CORDIC_GAIN;
        y    <= '0;
        z    <= folded;
        neg  <= fold_neg;
      end else if (busy) begin
        x <= x_n;
        y <= y_n;
        z <= z_n;
        k <= k + uvsph_pkg::ATAN_IW'(1);
        if (k == uvsph_pkg::ATAN_IW'(NSTEP - 1)) begin
          busy  <= 1'b0;
          done  <= 1'b1;
          sin_o <= neg ? -y_n : y_n;
          cos_o <= neg ? -x_n : x_n;
        end
      end
    end
  end

endmodule

// ----- src/uvsph_back.sv -----
// ============================================================================
// UV sphere tessellator back end
// Works out the cell's angles, sines and texture coordinates, then builds
// the six vertices and queues them for the result port.
// ============================================================================
module uvsph_back #(
  parameter int CORDIC_STEPS = uvsph_pkg::CORDIC_STEPS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cell_empty,
  input  uvsph_pkg::cell_t              cell_head,
  output logic                          cell_pop,
  input  logic [15:0]                   radius,
  input  logic [uvsph_pkg::CNT_W-1:0]   slices,
  input  logic [uvsph_pkg::CNT_W-1:0]   stacks,
  input  logic                          pop,
  output logic                          empty,
  output uvsph_pkg::vertex_t            head
);

  localparam int XY_W = uvsph_pkg::XY_W;
  localparam int PR_W = 2 * XY_W;
  localparam int PP_W = XY_W + 17;

  typedef enum logic [3:0] {
    S_IDLE, S_ERR, S_DIV_GO, S_DIV_WAIT, S_COR_GO, S_COR_WAIT, S_MUL1, S_MUL2, S_WRITE
  } state_t;

  state_t state;
  logic [uvsph_pkg::IDX_W-1:0] si;
  logic [uvsph_pkg::IDX_W-1:0] tj;
  logic [2:0] op;
  logic [2:0] corner;

  logic signed [uvsph_pkg::ANG_W-1:0] ang_a [2];
  logic signed [uvsph_pkg::ANG_W-1:0] ang_b [2];
  logic [uvsph_pkg::TEX_W-1:0] tu [2];
  logic [uvsph_pkg::TEX_W-1:0] tv [2];
  logic signed [XY_W-1:0] sa [2];
  logic signed [XY_W-1:0] ca [2];
  logic signed [XY_W-1:0] sb [2];
  logic signed [XY_W-1:0] cb [2];

  logic signed [PR_W-1:0] prod_x;
  logic signed [PR_W-1:0] prod_z;
  logic signed [XY_W-1:0] u_y1;
  logic signed [XY_W-1:0] u0;
  logic signed [XY_W-1:0] u1;
  logic signed [XY_W-1:0] u2;
  logic signed [PP_W-1:0] pp0;
  logic signed [PP_W-1:0] pp1;
  logic signed [PP_W-1:0] pp2;
  logic signed [XY_W-1:0] u0_c;
  logic signed [XY_W-1:0] u2_c;
  logic signed [16:0]     r_s;

  logic [uvsph_pkg::CNT_W-1:0] t_val;
  logic [uvsph_pkg::CNT_W-1:0] s_val;
  logic                        div_start;
  logic [uvsph_pkg::DIV_W-1:0] div_dividend;
  logic [uvsph_pkg::CNT_W-1:0] div_divisor;
  logic                        div_done;
  logic [uvsph_pkg::DIV_W-1:0] div_q;
  logic                        cor_start;
  logic signed [uvsph_pkg::ANG_W-1:0] cor_theta;
  logic                        cor_done;
  logic signed [XY_W-1:0]      cor_sin;
  logic signed [XY_W-1:0]      cor_cos;
  logic                        ds;
  logic                        dt;

  uvsph_pkg::vertex_t outq [8];
  logic [2:0] wr_ptr;
  logic [2:0] rd_ptr;
  logic [3:0] count;
  logic       out_full;
  logic       out_wr;
  logic       out_rd;
  uvsph_pkg::vertex_t wr_data;

  function automatic logic signed [XY_W-1:0] rnd30(input logic signed [PR_W-1:0] p);
    logic signed [PR_W-1:0] s;
    s = (p + (PR_W'(1) <<< 29)) >>> 30;
    return s[XY_W-1:0];
  endfunction

  function automatic logic signed [16:0] pos_sat(input logic signed [PP_W-1:0] p);
    logic signed [PP_W-1:0] s;
    s = (p + (PP_W'(1) <<< 29)) >>> 30;
    if (s > $signed(PP_W'(65535))) begin
      return 17'sd65535;
    end else if (s < -$signed(PP_W'(65535))) begin
      return -17'sd65535;
    end
    return s[16:0];
  endfunction

  function automatic logic signed [15:0] nrm_sat(input logic signed [XY_W-1:0] u);
    logic signed [XY_W-1:0] s;
    s = (u + (XY_W'(1) <<< 15)) >>> 16;
    if (s > $signed(XY_W'(16384))) begin
      return 16'sd16384;
    end else if (s < -$signed(XY_W'(16384))) begin
      return -16'sd16384;
    end
    return s[15:0];
  endfunction

  uvsph_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  uvsph_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .theta (cor_theta),
    .done  (cor_done),
    .sin_o (cor_sin),
    .cos_o (cor_cos)
  );

  assign cell_pop  = (state == S_IDLE) && !cell_empty;
  assign div_start = (state == S_DIV_GO);
  assign cor_start = (state == S_COR_GO);
  assign t_val     = {1'b0, tj} + uvsph_pkg::CNT_W'(op[0]);
  assign s_val     = {1'b0, si} + uvsph_pkg::CNT_W'(op[0]);
  assign cor_theta = op[1] ? ang_b[op[0]] : ang_a[op[0]];
  assign ds        = uvsph_pkg::corner_ds(corner);
  assign dt        = uvsph_pkg::corner_dt(corner);
  assign r_s       = $signed({1'b0, radius});
  assign u0_c      = rnd30(prod_x);
  assign u2_c      = rnd30(prod_z);

  always_comb begin
    case (op[2:1])
      2'd0: begin
        div_dividend = uvsph_pkg::DIV_W'(t_val) * uvsph_pkg::TWO_PI_U;
        div_divisor  = slices;
      end
      2'd1: begin
        div_dividend = uvsph_pkg::DIV_W'(s_val) * uvsph_pkg::PI_U;
        div_divisor  = stacks;
      end
      2'd2: begin
        div_dividend = uvsph_pkg::DIV_W'({t_val, 16'h0000}) +
                       uvsph_pkg::DIV_W'(slices >> 1);
        div_divisor  = slices;
      end
      default: begin
        div_dividend = uvsph_pkg::DIV_W'({s_val, 16'h0000}) +
                       uvsph_pkg::DIV_W'(stacks >> 1);
        div_divisor  = stacks;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      op     <= '0;
      corner <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!cell_empty) begin
            si     <= cell_head.stack;
            tj     <= cell_head.slice;
            op     <= '0;
            corner <= '0;
            state  <= cell_head.err ? S_ERR : S_DIV_GO;
          end
        end
        S_ERR: begin
          if (!out_full) begin
            state <= S_IDLE;
          end
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            case (op[2:1])
              2'd0:    ang_a[op[0]] <= $signed(div_q[uvsph_pkg::ANG_W-1:0]);
              2'd1:    ang_b[op[0]] <= $signed(div_q[uvsph_pkg::ANG_W-1:0]);
              2'd2:    tu[op[0]] <= div_q[uvsph_pkg::TEX_W-1:0];
              default: tv[op[0]] <= 17'd65536 - div_q[uvsph_pkg::TEX_W-1:0];
            endcase
            op    <= op + 3'd1;
            state <= (op == 3'd7) ? S_COR_GO : S_DIV_GO;
          end
        end
        S_COR_GO: state <= S_COR_WAIT;
        S_COR_WAIT: begin
          if (cor_done) begin
            if (op[1]) begin
              sb[op[0]] <= cor_sin;
              cb[op[0]] <= cor_cos;
            end else begin
              sa[op[0]] <= cor_sin;
              ca[op[0]] <= cor_cos;
            end
            op    <= op + 3'd1;
            state <= (op == 3'd3) ? S_MUL1 : S_COR_GO;
          end
        end
        S_MUL1: begin
          prod_x <= sb[ds] * ca[dt];
          prod_z <= sb[ds] * sa[dt];
          u_y1   <= cb[ds];
          state  <= S_MUL2;
        end
        S_MUL2: begin
          u0    <= u0_c;
          u1    <= u_y1;
          u2    <= u2_c;
          pp0   <= u0_c * r_s;
          pp1   <= u_y1 * r_s;
          pp2   <= u2_c * r_s;
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (!out_full) begin
            corner <= corner + 3'd1;
            state  <= (corner == 3'd5) ? S_IDLE : S_MUL1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    wr_data = '0;
    if (state == S_ERR) begin
      wr_data.index_error = 1'b1;
    end else begin
      wr_data.vertex_x      = pos_sat(pp0);
      wr_data.vertex_y      = pos_sat(pp1);
      wr_data.vertex_z      = pos_sat(pp2);
      wr_data.normal_x      = (radius != '0) ? nrm_sat(u0) : '0;
      wr_data.normal_y      = (radius != '0) ? nrm_sat(u1) : '0;
      wr_data.normal_z      = (radius != '0) ? nrm_sat(u2) : '0;
      wr_data.tex_u         = tu[dt];
      wr_data.tex_v         = tv[ds];
      wr_data.corner_number = corner;
      wr_data.last_of_cell  = (corner == 3'd5);
    end
  end

  assign out_full = (count == 4'd8);
  assign empty    = (count == 4'd0);
  assign out_wr   = ((state == S_ERR) || (state == S_WRITE)) && !out_full;
  assign out_rd   = pop && !empty;
  assign head     = outq[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (out_wr) begin
        outq[wr_ptr] <= wr_data;
        wr_ptr       <= wr_ptr + 3'd1;
      end
      if (out_rd) begin
        rd_ptr <= rd_ptr + 3'd1;
      end
      case ({out_wr, out_rd})
        2'b10:   count <= count + 4'd1;
        2'b01:   count <= count - 4'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- src/uv_sphere_cell_tessellator_unit.sv -----
// ============================================================================
// UV sphere cell tessellator
// Turns one grid cell of a UV sphere into six vertices with normals and
// texture coordinates, configured through an APB-style register port.
// ============================================================================
// A cell pushed in is queued (four deep) and then expanded into six vertex
// transactions on the result queue, in the corner order p2,p4,p3,p3,p1,p2;
// a cell outside the configured grid gives a single transaction flagged as
// an index error. For a valid cell, once it leaves the input queue, the
// single bit-serial divider forms the four angles and four texture
// coordinates, followed by the shared one-step-per-cycle CORDIC for the
// sines and cosines of the angles; each vertex then takes two multiply
// steps and is written when the result queue has room. Registers: radius
// at 0x0, slice count at 0x4 and stack count at 0x8; they should only be
// written while the block is idle.
module uv_sphere_cell_tessellator_unit #(
  parameter int CORDIC_STEPS = uvsph_pkg::CORDIC_STEPS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                push,
  output logic                                full,
  input  logic [uvsph_pkg::IDX_W-1:0]         stack_index,
  input  logic [uvsph_pkg::IDX_W-1:0]         slice_index,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [uvsph_pkg::POS_W-1:0]  vertex_x,
  output logic signed [uvsph_pkg::POS_W-1:0]  vertex_y,
  output logic signed [uvsph_pkg::POS_W-1:0]  vertex_z,
  output logic signed [uvsph_pkg::NRM_W-1:0]  normal_x,
  output logic signed [uvsph_pkg::NRM_W-1:0]  normal_y,
  output logic signed [uvsph_pkg::NRM_W-1:0]  normal_z,
  output logic [uvsph_pkg::TEX_W-1:0]         tex_u,
  output logic [uvsph_pkg::TEX_W-1:0]         tex_v,
  output logic [2:0]                          corner_number,
  output logic                                last_of_cell,
  output logic                                index_error
);

  logic [15:0]                 radius;
  logic [uvsph_pkg::CNT_W-1:0] slice_count;
  logic [uvsph_pkg::CNT_W-1:0] stack_count;
  logic [uvsph_pkg::CNT_W-1:0] slices;
  logic [uvsph_pkg::CNT_W-1:0] stacks;
  logic                        cfg_wr;
  logic                        cell_pop;
  logic                        cell_empty;
  uvsph_pkg::cell_t            cell_head;
  uvsph_pkg::vertex_t          head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign slices = uvsph_pkg::eff_count(slice_count);
  assign stacks = uvsph_pkg::eff_count(stack_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= 16'd256;
      slice_count <= uvsph_pkg::CNT_W'(16);
      stack_count <= uvsph_pkg::CNT_W'(16);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        uvsph_pkg::REG_RADIUS: radius      <= pwdata[15:0];
        uvsph_pkg::REG_SLICES: slice_count <= pwdata[uvsph_pkg::CNT_W-1:0];
        uvsph_pkg::REG_STACKS: stack_count <= pwdata[uvsph_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      uvsph_pkg::REG_RADIUS: prdata = 32'(radius);
      uvsph_pkg::REG_SLICES: prdata = 32'(slice_count);
      uvsph_pkg::REG_STACKS: prdata = 32'(stack_count);
      default:               prdata = '0;
    endcase
  end

  uvsph_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .stack_index (stack_index),
    .slice_index (slice_index),
    .slices      (slices),
    .stacks      (stacks),
    .cell_pop    (cell_pop),
    .cell_empty  (cell_empty),
    .cell_head   (cell_head)
  );

  uvsph_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cell_empty (cell_empty),
    .cell_head  (cell_head),
    .cell_pop   (cell_pop),
    .radius     (radius),
    .slices     (slices),
    .stacks     (stacks),
    .pop        (pop),
    .empty      (empty),
    .head       (head)
  );

  assign vertex_x      = head.vertex_x;
  assign vertex_y      = head.vertex_y;
  assign vertex_z      = head.vertex_z;
  assign normal_x      = head.normal_x;
  assign normal_y      = head.normal_y;
  assign normal_z      = head.normal_z;
  assign tex_u         = head.tex_u;
  assign tex_v         = head.tex_v;
  assign corner_number = head.corner_number;
  assign last_of_cell  = head.last_of_cell;
  assign index_error   = head.index_error;

endmodule
